FILE: rtl/address_to_symbol_lookup_macros.svh
// ----------------------------------------------------------------------------
// Address-to-symbol lookup: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_TO_SYMBOL_LOOKUP_MACROS_SVH
`define ADDRESS_TO_SYMBOL_LOOKUP_MACROS_SVH

`ifndef SYNTH
// plain property, checked at every rising clock edge out of reset
`define A2S_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define A2S_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define A2S_ASSERT(label, clk, rst_n, prop, msg)
`define A2S_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/a2s_pkg.sv
// ----------------------------------------------------------------------------
// Address-to-symbol lookup package
// Opcodes, sequencer states and the compare unit result type.
// ----------------------------------------------------------------------------
`default_nettype none

package a2s_pkg;

  localparam logic [15:0] MIN_ADDR_RESET = 16'd32;

  typedef enum logic [1:0] {
    OP_ADD_SEG = 2'd0,
    OP_ADD_SYM = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SEG_RD  = 9'b000000010,
    S_SEG_CMP = 9'b000000100,
    S_SYM_RD  = 9'b000001000,
    S_SYM_CMP = 9'b000010000,
    S_FIN_RD  = 9'b000100000,
    S_FIN_CMP = 9'b001000000,
    S_MIN_CMP = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  typedef struct packed {
    logic a_lt_b;   // signed a < b
    logic a_eq_b;
    logic diff_lt;  // unsigned (a - b) < len
    logic diff_le;  // unsigned (a - b) <= len
  } alu_res_t;

endpackage

`default_nettype wire

FILE: rtl/a2s_alu.sv
// ----------------------------------------------------------------------------
// Address-to-symbol lookup compare unit
// Shared signed compare plus difference-against-length check.
// ----------------------------------------------------------------------------
`default_nettype none

module a2s_alu (
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  input  logic [63:0]       len_i,
  output a2s_pkg::alu_res_t res_o
);
  import a2s_pkg::*;

  logic [63:0] diff;

  // exact whenever a >= b signed: the true difference fits in 64 unsigned bits
  assign diff = a_i - b_i;

  always_comb begin
    res_o.a_lt_b  = $signed(a_i) < $signed(b_i);
    res_o.a_eq_b  = (a_i == b_i);
    res_o.diff_lt = (diff < len_i);
    res_o.diff_le = !(len_i < diff);
  end

endmodule

`default_nettype wire

FILE: rtl/address_to_symbol_lookup.sv
// ----------------------------------------------------------------------------
// Address-to-symbol lookup
// Segment table scan followed by an upper-bound binary search of a sorted
// symbol table, all on one shared compare unit.
// ----------------------------------------------------------------------------
// Add segment, add symbol and clear give no result. A query reads and
// compares each segment scanned, then one symbol per search probe (at most
// ceil(log2(count+1)) probes), then reads and checks the candidate, compares
// it with the limit and loads the output register, waiting while the output
// is stalled; input stalls until then. All steps share the single compare
// unit. Reset empties both tables and sets min_symbol_address to 32.
`default_nettype none

`include "address_to_symbol_lookup_macros.svh"

module address_to_symbol_lookup #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_SYMBOLS  = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [63:0] address_i,
  input  logic [63:0]        length_i,
  input  logic               executable_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               in_program_o,
  output logic               is_text_o,
  output logic               found_o,
  output logic [9:0]         symbol_index_o
);
  import a2s_pkg::*;

  localparam int SegCw = $clog2(MAX_SEGMENTS + 1);
  localparam int SegAw = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SymCw = $clog2(MAX_SYMBOLS + 1);
  localparam int SymAw = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  state_e state_q, state_d;

  logic [15:0]      min_addr_q;
  logic [SegCw-1:0] seg_count_q, seg_count_d;
  logic [SymCw-1:0] sym_count_q, sym_count_d;
  logic [SegCw-1:0] seg_idx_q, seg_idx_d;
  logic [SymCw-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [63:0]      addr_q, addr_d;
  logic             inprog_q, inprog_d, text_q, text_d;
  logic             found_q, found_d, match_q, match_d;
  logic [9:0]       idx_q, idx_d;

  logic             out_valid_q, out_valid_d;
  logic             out_inprog_q, out_inprog_d, out_text_q, out_text_d;
  logic             out_found_q, out_found_d;
  logic [9:0]       out_idx_q, out_idx_d;

  // tables: seg entry {exec, length, base}, sym entry {length, address}
  logic [128:0] seg_mem [MAX_SEGMENTS];
  logic [127:0] sym_mem [MAX_SYMBOLS];
  logic [128:0] seg_rd_q;
  logic [127:0] sym_rd_q;

  logic             in_acc, seg_we, sym_we;
  logic [SymCw:0]   mid_sum;
  logic [SymCw-1:0] mid, hi_m1, sym_rd_addr;
  logic [SymCw+9:0] hi_m1_ext;
  logic [63:0]      alu_a, alu_b, alu_len;
  alu_res_t         alu_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign seg_we      = in_acc && (op_e'(op_i) == OP_ADD_SEG)
                       && (seg_count_q < SegCw'(MAX_SEGMENTS));
  assign sym_we      = in_acc && (op_e'(op_i) == OP_ADD_SYM)
                       && (sym_count_q < SymCw'(MAX_SYMBOLS));

  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = mid_sum[SymCw:1];
  assign hi_m1       = hi_q - SymCw'(1);
  assign hi_m1_ext   = {10'd0, hi_m1};
  assign sym_rd_addr = (state_q == S_SYM_RD || state_q == S_SYM_CMP) ? mid : hi_m1;

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_count_q[SegAw-1:0]] <= {executable_i, length_i, address_i};
    end
    seg_rd_q <= seg_mem[seg_idx_q[SegAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_count_q[SymAw-1:0]] <= {length_i, address_i};
    end
    sym_rd_q <= sym_mem[sym_rd_addr[SymAw-1:0]];
  end

  // operand select for the shared compare unit
  always_comb begin
    alu_a   = addr_q;
    alu_b   = sym_rd_q[63:0];
    alu_len = sym_rd_q[127:64];
    if (state_q == S_SEG_CMP) begin
      alu_b   = seg_rd_q[63:0];
      alu_len = seg_rd_q[127:64];
    end else if (state_q == S_MIN_CMP) begin
      alu_a = sym_rd_q[63:0];
      alu_b = {48'd0, min_addr_q};
    end
  end

  a2s_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .len_i (alu_len),
    .res_o (alu_res)
  );

  always_comb begin
    state_d      = state_q;
    seg_count_d  = seg_count_q;
    sym_count_d  = sym_count_q;
    seg_idx_d    = seg_idx_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    addr_d       = addr_q;
    inprog_d     = inprog_q;
    text_d       = text_q;
    found_d      = found_q;
    match_d      = match_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_inprog_d = out_inprog_q;
    out_text_d   = out_text_q;
    out_found_d  = out_found_q;
    out_idx_d    = out_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(op_i))
            OP_ADD_SEG: begin
              if (seg_we) seg_count_d = seg_count_q + SegCw'(1);
            end
            OP_ADD_SYM: begin
              if (sym_we) sym_count_d = sym_count_q + SymCw'(1);
            end
            OP_CLEAR: begin
              seg_count_d = '0;
              sym_count_d = '0;
            end
            OP_QUERY: begin
              addr_d    = address_i;
              seg_idx_d = '0;
              inprog_d  = 1'b0;
              text_d    = 1'b0;
              found_d   = 1'b0;
              idx_d     = '0;
              state_d   = (seg_count_q == '0) ? S_DONE : S_SEG_RD;
            end
            default: ;
          endcase
        end
      end
      S_SEG_RD: state_d = S_SEG_CMP;
      S_SEG_CMP: begin
        if (!alu_res.a_lt_b && alu_res.diff_lt) begin
          // first containing segment wins
          inprog_d = 1'b1;
          text_d   = seg_rd_q[128];
          lo_d     = '0;
          hi_d     = sym_count_q;
          state_d  = (sym_count_q == '0) ? S_DONE : S_SYM_RD;
        end else if (seg_idx_q + SegCw'(1) == seg_count_q) begin
          state_d = S_DONE;
        end else begin
          seg_idx_d = seg_idx_q + SegCw'(1);
          state_d   = S_SEG_RD;
        end
      end
      S_SYM_RD: state_d = S_SYM_CMP;
      S_SYM_CMP: begin
        if (alu_res.a_lt_b) begin
          hi_d = mid;
        end else begin
          lo_d = mid + SymCw'(1);
        end
        if (lo_d < hi_d) begin
          state_d = S_SYM_RD;
        end else if (hi_d == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      S_FIN_RD: state_d = S_FIN_CMP;
      S_FIN_CMP: begin
        // zero length covers everything above the symbol
        match_d = alu_res.a_eq_b ||
                  (!alu_res.a_lt_b && (alu_res.diff_le || alu_len == '0));
        state_d = S_MIN_CMP;
      end
      S_MIN_CMP: begin
        if (match_q && !alu_res.a_lt_b) begin
          found_d = 1'b1;
          idx_d   = hi_m1_ext[9:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_inprog_d = inprog_q;
          out_text_d   = text_q;
          out_found_d  = found_q;
          out_idx_d    = idx_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_count_q <= '0;
      sym_count_q <= '0;
      min_addr_q  <= MIN_ADDR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_count_q <= seg_count_d;
      sym_count_q <= sym_count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        min_addr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_idx_q    <= seg_idx_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    addr_q       <= addr_d;
    inprog_q     <= inprog_d;
    text_q       <= text_d;
    found_q      <= found_d;
    match_q      <= match_d;
    idx_q        <= idx_d;
    out_inprog_q <= out_inprog_d;
    out_text_q   <= out_text_d;
    out_found_q  <= out_found_d;
    out_idx_q    <= out_idx_d;
  end

  assign out_valid_o    = out_valid_q;
  assign in_program_o   = out_inprog_q;
  assign is_text_o      = out_text_q;
  assign found_o        = out_found_q;
  assign symbol_index_o = out_idx_q;

  `A2S_ASSERT_IMP(a_found_in_prog, clk_i, rst_ni, out_valid_q && out_found_q,
                  out_inprog_q, "found result outside program")
  `A2S_ASSERT_IMP(a_idx_zero, clk_i, rst_ni, out_valid_q && !out_found_q,
                  out_idx_q == '0, "nonzero index without match")
  `A2S_ASSERT_IMP(a_search_bounds, clk_i, rst_ni,
                  state_q == S_SYM_RD || state_q == S_SYM_CMP,
                  lo_q < hi_q && hi_q <= sym_count_q, "search window out of range")
  `A2S_ASSERT(a_count_bounds, clk_i, rst_ni,
              seg_count_q <= SegCw'(MAX_SEGMENTS) && sym_count_q <= SymCw'(MAX_SYMBOLS),
              "table count overflow")

endmodule

`default_nettype wire

FILE: dv/address_to_symbol_lookup_test.sv
// ----------------------------------------------------------------------------
// Address-to-symbol lookup testbench
// A directed table of segment, symbol, query and clear transactions comes
// first. Random scenarios follow: tables rebuilt with sorted symbols, plus
// noise, unsorted tables and a full segment table. An in-bench model of both
// tables predicts random query results; all are checked in order. Both
// handshakes see random stalls, and the limit register moves between phases.
// ----------------------------------------------------------------------------
module address_to_symbol_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;

  import a2s_pkg::*;

  localparam int SEG_SLOTS = 16;
  localparam int SYM_SLOTS = 1024;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       in_program;
    logic       is_text;
    logic       found;
    logic [9:0] symbol_index;
  } lookup_t;

  typedef struct packed {
    op_e         op;
    logic [63:0] address;
    logic [63:0] length;
    logic        executable;
    logic        typed;
    lookup_t     result;
  } step_row_t;

  localparam lookup_t MISS      = '0;
  localparam lookup_t CODE_ONLY = '{1'b1, 1'b1, 1'b0, 10'd0};
  localparam lookup_t DATA_ONLY = '{1'b1, 1'b0, 1'b0, 10'd0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_QUERY;
  logic signed [63:0] address_i = '0;
  logic [63:0]        length_i = '0;
  logic               executable_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               in_program_o;
  logic               is_text_o;
  logic               found_o;
  logic [9:0]         symbol_index_o;

  // model of the block's tables
  logic [63:0] seg_base [SEG_SLOTS];
  logic [63:0] seg_size [SEG_SLOTS];
  logic        seg_exec [SEG_SLOTS];
  int          seg_fill = 0;
  logic [63:0] sym_addr [SYM_SLOTS];
  logic [63:0] sym_size [SYM_SLOTS];
  int          sym_fill = 0;
  logic [15:0] min_sym_addr = MIN_ADDR_RESET;

  lookup_t pending_lookups[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;
  bit      long_hold = 1'b0;

  // Segments 0 and 1 overlap; the third starts near the signed top; the fourth
  // covers the bottom of the signed range. Symbol 0 lies below the limit.
  step_row_t directed_rows [25] = '{
    '{OP_QUERY,   64'h0,    64'h0, 1'b0, 1'b1, MISS},
    '{OP_ADD_SEG, 64'h1000, 64'h1000, 1'b1, 1'b0, MISS},
    '{OP_ADD_SEG, 64'h1800, 64'h1000, 1'b0, 1'b0, MISS},
    '{OP_ADD_SEG, 64'h7FFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, MISS},
    '{OP_QUERY,   64'h0FFF, 64'h0, 1'b0, 1'b1, MISS},
    '{OP_QUERY,   64'h1000, 64'h0, 1'b0, 1'b1, CODE_ONLY},
    '{OP_QUERY,   64'h1FFF, 64'h0, 1'b0, 1'b1, CODE_ONLY},
    '{OP_QUERY,   64'h2000, 64'h0, 1'b0, 1'b1, DATA_ONLY},
    '{OP_QUERY,   64'h2800, 64'h0, 1'b0, 1'b1, MISS},
    '{OP_QUERY,   64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1, CODE_ONLY},
    '{OP_ADD_SYM, 64'h10,   64'h100, 1'b0, 1'b0, MISS},
    '{OP_ADD_SYM, 64'h1000, 64'h10, 1'b0, 1'b0, MISS},
    '{OP_ADD_SYM, 64'h1100, 64'h0, 1'b0, 1'b0, MISS},
    '{OP_ADD_SYM, 64'h1800, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, MISS},
    '{OP_QUERY,   64'h1000, 64'h0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 10'd1}},
    '{OP_QUERY,   64'h1010, 64'h0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 10'd1}},
    '{OP_QUERY,   64'h1011, 64'h0, 1'b0, 1'b1, CODE_ONLY},
    '{OP_QUERY,   64'h1500, 64'h0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 10'd2}},
    '{OP_QUERY,   64'h2000, 64'h0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 10'd3}},
    '{OP_ADD_SEG, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0100, 1'b0, 1'b0, MISS},
    '{OP_QUERY,   64'h20,   64'h0, 1'b0, 1'b1, DATA_ONLY},
    '{OP_QUERY,   64'h8000_0000_0000_0000, 64'h0, 1'b0, 1'b1, DATA_ONLY},
    '{OP_QUERY,   64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b1, 10'd3}},
    '{OP_CLEAR,   64'h0,    64'h0, 1'b0, 1'b0, MISS},
    '{OP_QUERY,   64'h1000, 64'h0, 1'b0, 1'b1, MISS}
  };

  address_to_symbol_lookup #(
    .MAX_SEGMENTS (SEG_SLOTS),
    .MAX_SYMBOLS  (SYM_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .address_i      (address_i),
    .length_i       (length_i),
    .executable_i   (executable_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .in_program_o   (in_program_o),
    .is_text_o      (is_text_o),
    .found_o        (found_o),
    .symbol_index_o (symbol_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string what);
    if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Segment scan, then upper-bound search for the last symbol not above addr.
  function automatic lookup_t resolve_address(logic [63:0] addr);
    lookup_t     r;
    int unsigned lo, hi, mid;
    logic [63:0] sa, sl;
    r = '0;
    for (int i = 0; i < seg_fill; i++) begin
      if (!($signed(addr) < $signed(seg_base[i])) && (addr - seg_base[i]) < seg_size[i]) begin
        r.in_program = 1'b1;
        r.is_text = seg_exec[i];
        break;
      end
    end
    if (!r.in_program) return r;
    lo = 0;
    hi = sym_fill;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if ($signed(addr) < $signed(sym_addr[mid])) hi = mid;
      else lo = mid + 1;
    end
    if (hi == 0) return r;
    sa = sym_addr[hi - 1];
    sl = sym_size[hi - 1];
    if ($signed(sa) < $signed({48'd0, min_sym_addr})) return r;
    if (addr == sa || ($signed(sa) < $signed(addr) && ((addr - sa) <= sl || sl == '0))) begin
      r.found = 1'b1;
      r.symbol_index = 10'(hi - 1);
    end
    return r;
  endfunction

  task automatic track_item(op_e op, logic [63:0] addr, logic [63:0] len, logic exe,
                            logic typed, lookup_t typed_res);
    case (op)
      OP_ADD_SEG: begin
        if (seg_fill < SEG_SLOTS) begin
          seg_base[seg_fill] = addr;
          seg_size[seg_fill] = len;
          seg_exec[seg_fill] = exe;
          seg_fill++;
        end
      end
      OP_ADD_SYM: begin
        if (sym_fill < SYM_SLOTS) begin
          sym_addr[sym_fill] = addr;
          sym_size[sym_fill] = len;
          sym_fill++;
        end
      end
      OP_CLEAR: begin
        seg_fill = 0;
        sym_fill = 0;
      end
      default: pending_lookups.push_back(typed ? typed_res : resolve_address(addr));
    endcase
  endtask

  // Valid stays high across back-to-back transactions; it drops only for a gap.
  task automatic send_item(op_e op, logic [63:0] addr, logic [63:0] len, logic exe,
                           logic typed = 1'b0, lookup_t typed_res = '0);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    address_i <= addr;
    length_i <= len;
    executable_i <= exe;
    do @(posedge clk_i); while (in_stall_o);
    track_item(op, addr, len, exe, typed, typed_res);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    // adds leave no result behind, so give the last one time to land
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_min_symbol(logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_sym_addr = value;
  endtask

  // Rebuild the tables around a window and query mostly near symbols.
  task automatic run_scenario(int n_seg, int n_sym, int n_query, bit sorted, bit noisy);
    logic [63:0] window, cursor, a, l;
    int          cover_at, k;
    window = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 64)) : {$urandom, $urandom};
    cover_at = (n_seg > SEG_SLOTS) ? 0 : n_seg - 1;
    if ($urandom_range(0, 5) != 0)
      send_item(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n_seg; i++) begin
      if (i == cover_at) begin
        a = window - 64'h1000;
        l = 64'(n_sym) * 64'h180 + 64'h3000;
      end else begin
        a = window + 64'($urandom_range(0, 'h3000)) - 64'h800;
        case ($urandom_range(0, 7))
          0: l = '0;
          1: l = {$urandom, $urandom};
          default: l = 64'($urandom_range(1, 'h6000));
        endcase
      end
      send_item(OP_ADD_SEG, a, l, 1'($urandom_range(0, 1)));
    end
    cursor = window - 64'($urandom_range(0, 'h100));
    for (int i = 0; i < n_sym; i++) begin
      cursor = cursor + 64'($urandom_range(0, 'h180));
      a = sorted ? cursor : window + 64'($urandom_range(0, 'h4000));
      case ($urandom_range(0, 15))
        0, 1: l = '0;
        2: l = {$urandom, $urandom};
        default: l = 64'($urandom_range(0, 'h100));
      endcase
      send_item(OP_ADD_SYM, a, l, 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < n_query; i++) begin
      k = $urandom_range(0, 9);
      if (k == 9 && noisy) begin
        send_item(op_e'($urandom_range(0, 2)), {$urandom, $urandom}, {$urandom, $urandom},
                  1'($urandom_range(0, 1)));
        continue;
      end
      if (k <= 5 && sym_fill > 0) begin
        k = $urandom_range(0, sym_fill - 1);
        case ($urandom_range(0, 3))
          0: a = sym_addr[k];
          1: a = sym_addr[k] + sym_size[k];
          2: a = sym_addr[k] + sym_size[k] + 64'd1;
          default: a = sym_addr[k] + 64'($urandom_range(0, 'h40)) - 64'd4;
        endcase
      end else if (k == 8) begin
        a = {$urandom, $urandom};
      end else begin
        a = window + 64'($urandom_range(0, 'h4000)) - 64'h800;
      end
      send_item(OP_QUERY, a, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : result_backpressure
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    lookup_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {in_program_o, is_text_o, found_o, symbol_index_o};
      if (pending_lookups.size() == 0) begin
        flag_mismatch($sformatf("result %p with no query outstanding", got));
      end else begin
        want = pending_lookups.pop_front();
        if (got.in_program !== want.in_program)
          flag_mismatch($sformatf("in_program %b, want %b", got.in_program, want.in_program));
        if (got.is_text !== want.is_text)
          flag_mismatch($sformatf("is_text %b, want %b", got.is_text, want.is_text));
        if (got.found !== want.found)
          flag_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.symbol_index !== want.symbol_index)
          flag_mismatch($sformatf("symbol_index %0d, want %0d",
                                  got.symbol_index, want.symbol_index));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].op, directed_rows[r].address, directed_rows[r].length,
                directed_rows[r].executable, directed_rows[r].typed, directed_rows[r].result);
    end

    set_min_symbol(16'hFFFF);
    run_scenario(6, 12, 30, 1'b1, 1'b0);
    run_scenario(4, 10, 20, 1'b1, 1'b1);

    set_min_symbol(16'h0000);
    long_hold = 1'b1;
    run_scenario(5, 16, 24, 1'b1, 1'b0);
    run_scenario(18, 8, 20, 1'b1, 1'b1);   // segment table overflows
    run_scenario(4, 20, 25, 1'b0, 1'b1);   // symbols out of order

    set_min_symbol(16'($urandom));
    run_scenario(17, 300, 40, 1'b1, 1'b0);  // full segment table, deep search

    set_min_symbol(MIN_ADDR_RESET);
    repeat (3) begin
      run_scenario($urandom_range(1, 12), $urandom_range(0, 40), $urandom_range(15, 40),
                   $urandom_range(0, 7) != 0, 1'b1);
      if ($urandom_range(0, 1) == 0) drain_results();
    end

    set_min_symbol(16'($urandom));
    calm = 1'b1;
    run_scenario(8, 24, 40, 1'b1, 1'b0);

    drain_results();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
